[src/lru_key_value_cache_macros.svh]
// assertion helpers shared by the checker
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// clocked property, off while reset is low
`define LKV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must hold whenever a result is shown
`define LKV_ASSERT_VALID(label, clk, rst_n, vld, cond, msg) \
  `LKV_ASSERT(label, clk, rst_n, vld |-> (cond), msg)

`endif

[src/lkv_pkg.sv]
package lkv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [DATA_W-1:0] READ_MISS = 32'hFFFF_FFFF;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic update;
  } cmd_t;

endpackage

[src/lkv_if.sv]
interface lkv_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [lkv_pkg::DATA_W-1:0] lookup_key;
  logic signed [lkv_pkg::DATA_W-1:0] store_value;

  modport source (output valid, mode, lookup_key, store_value, input ready);
  modport sink   (input valid, mode, lookup_key, store_value, output ready);
endinterface

interface lkv_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic signed [lkv_pkg::DATA_W-1:0] read_value;
  logic                              evicted;
  logic signed [lkv_pkg::DATA_W-1:0] evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

[src/lkv_ctrl.sv]
module lkv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lkv_pkg::cmd_t cmd
);

  lkv_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lkv_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lkv_pkg::ST_MATCH;
      end
      lkv_pkg::ST_MATCH: begin
        state_nxt = lkv_pkg::ST_UPDATE;
      end
      lkv_pkg::ST_UPDATE: begin
        // wait here until the result register can take the item
        if (out_free) state_nxt = lkv_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lkv_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.match   = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      lkv_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      lkv_pkg::ST_MATCH: begin
        cmd.match = 1'b1;
      end
      lkv_pkg::ST_UPDATE: begin
        cmd.update = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/lkv_dp.sv]
module lkv_dp #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lkv_pkg::cmd_t                     cmd,
  input  logic                              in_mode,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_lookup_key,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_store_value,
  input  logic                              cfg_we,
  input  logic        [lkv_pkg::CAP_W-1:0]  cfg_wdata,
  output logic                              out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0] out_read_value,
  output logic                              out_evicted,
  output logic signed [lkv_pkg::DATA_W-1:0] out_evicted_key
);

  localparam int DW = lkv_pkg::DATA_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  // request
  logic          req_put_r;
  logic [DW-1:0] req_key_r;
  logic [DW-1:0] req_val_r;

  // store
  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic [DW-1:0]             keys_r [ENTRIES];
  logic [DW-1:0]             vals_r [ENTRIES];
  logic [IW-1:0]             rank_r [ENTRIES];
  logic [ENTRIES-1:0]        valid_r, valid_nxt;
  logic [CW-1:0]             count_r, count_nxt;

  // lookup results
  logic [ENTRIES-1:0] found_r, lru_r;
  logic               hit_r, evict_r;

  logic [ENTRIES-1:0] match_vec, lru_vec;
  logic [IW-1:0]      count_m1;
  logic [EW-1:0]      eff_cap;
  logic               need_evict;

  logic [IW-1:0]      found_idx, lru_idx, slot_idx;
  logic [IW-1:0]      found_rank;
  logic               do_evict, has_slot, put_miss;
  logic [ENTRIES-1:0] valid_after;

  logic          out_hit_r, out_evicted_r;
  logic [DW-1:0] out_read_r, out_evk_r;

  // lookup phase: parallel key compare and lru pick
  assign count_m1 = IW'(count_r - CW'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (keys_r[i] == req_key_r);
      // valid ranks are a permutation of 0..count-1
      lru_vec[i]   = valid_r[i] && (rank_r[i] == count_m1);
    end
  end

  always_comb begin
    if (cap_r == '0) eff_cap = EW'(1);
    else if (EW'(cap_r) > EW'(ENTRIES)) eff_cap = EW'(ENTRIES);
    else eff_cap = EW'(cap_r);
  end

  assign need_evict = EW'(count_r) >= eff_cap;

  // update phase
  always_comb begin
    found_idx = '0;
    lru_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (found_r[i]) found_idx = found_idx | IW'(i);
      if (lru_r[i])   lru_idx   = lru_idx | IW'(i);
    end
  end

  assign found_rank  = rank_r[found_idx];
  assign put_miss    = req_put_r && !hit_r;
  assign do_evict    = put_miss && evict_r && (|lru_r);
  assign valid_after = valid_r & ~(do_evict ? lru_r : '0);

  // lowest free slot
  always_comb begin
    has_slot = 1'b0;
    slot_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        has_slot = 1'b1;
        slot_idx = IW'(i);
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (put_miss) begin
      valid_nxt = valid_after;
      if (has_slot) valid_nxt[slot_idx] = 1'b1;
      count_nxt = count_r - CW'(do_evict) + CW'(has_slot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= lkv_pkg::CAP_RESET;
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      if (cmd.update) begin
        valid_r <= valid_nxt;
        count_r <= count_nxt;
        if (hit_r) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i] && rank_r[i] < found_rank) rank_r[i] <= rank_r[i] + IW'(1);
          end
          rank_r[found_idx] <= '0;
        end else if (req_put_r && has_slot) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_after[i]) rank_r[i] <= rank_r[i] + IW'(1);
          end
          rank_r[slot_idx] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_put_r <= (in_mode == lkv_pkg::MODE_PUT);
      req_key_r <= in_lookup_key;
      req_val_r <= in_store_value;
    end
    if (cmd.match) begin
      found_r <= match_vec;
      lru_r   <= lru_vec;
      hit_r   <= |match_vec;
      evict_r <= need_evict;
    end
    if (cmd.update) begin
      if (hit_r && req_put_r) vals_r[found_idx] <= req_val_r;
      if (put_miss && has_slot) begin
        keys_r[slot_idx] <= req_key_r;
        vals_r[slot_idx] <= req_val_r;
      end
      out_hit_r     <= hit_r;
      out_read_r    <= (hit_r && !req_put_r) ? vals_r[found_idx] : lkv_pkg::READ_MISS;
      out_evicted_r <= do_evict;
      out_evk_r     <= do_evict ? keys_r[lru_idx] : '0;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evk_r;

endmodule

[src/lru_key_value_cache.sv]
// flow: an item passes accept, key compare and update in turn, and a new
//   item is taken only once the last one is through; a held result
//   stalls the update step
// reset: synchronous active low; clears entries, recency, count and the
//   result valid, capacity returns to 16; no clearing pass
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lkv_in_if.sink                           in_chan,
  lkv_out_if.source                        out_chan,
  input  logic                             cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_wdata
);

  lkv_pkg::cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  lkv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_chan.mode),
    .in_lookup_key   (in_chan.lookup_key),
    .in_store_value  (in_chan.store_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_hit         (out_chan.hit),
    .out_read_value  (out_chan.read_value),
    .out_evicted     (out_chan.evicted),
    .out_evicted_key (out_chan.evicted_key)
  );

endmodule

[src/lkv_checker.sv]
`include "lru_key_value_cache_macros.svh"

module lkv_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_hit,
  input logic [lkv_pkg::DATA_W-1:0] out_read_value,
  input logic                      out_evicted,
  input logic [lkv_pkg::DATA_W-1:0] out_evicted_key
);

  `LKV_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
  `LKV_ASSERT(a_one_item, clk, rst_n, in_valid && in_ready |=> !in_ready, "second item taken during lookup")
  `LKV_ASSERT_VALID(a_miss_value, clk, rst_n, out_valid, out_hit || out_read_value == lkv_pkg::READ_MISS, "miss without all-ones value")
  `LKV_ASSERT_VALID(a_evict_key, clk, rst_n, out_valid, out_evicted || out_evicted_key == '0, "evicted key set without eviction")
  `LKV_ASSERT_VALID(a_evict_miss, clk, rst_n, out_valid, !(out_evicted && out_hit), "eviction on a hit")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_hit         (out_chan.hit),
  .out_read_value  (out_chan.read_value),
  .out_evicted     (out_chan.evicted),
  .out_evicted_key (out_chan.evicted_key)
);
